// ===== src/lds_pkg.sv =====
// Shared types and constants for the LOOK disk scheduler.
// Depends on nothing; the cell and the top level import it.
package lds_pkg;

    localparam int CYL_W = 16;
    localparam int MOVE_W = 17;
    localparam int TOTAL_W = 18;
    localparam int SUM_W = TOTAL_W + 1;
    localparam int CFG_IDX_W = 1;

    localparam int MAX_REQUESTS_DEF = 32;
    localparam int CYLINDER_BITS_DEF = 16;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam logic [MOVE_W-1:0] MOVE_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_HEAD  = 1'b0,
        REG_SWEEP_RIGHT = 1'b1
    } cfg_reg_t;

    // Command broadcast to every cell of the ring
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_ROT_DN = 2'd2,
        OP_ROT_UP = 2'd3
    } cell_op_t;

endpackage

// ===== src/look_disk_scheduler.sv =====
// LOOK disk scheduler: requests are inserted one per cycle while collecting, sorted, into a
// ring of cells. On batch_end the ring first rotates past the low requests (below the head,
// or at it when sweeping left; one per cycle), then releases about one visit per cycle
// while the output is not stalled.
// Throughput: one request per cycle while collecting; no request is taken during release.
// Reset (aresetn, synchronous, low): ring empty, head 0, sweep right, no result pending.
module look_disk_scheduler import lds_pkg::*; #(
    parameter int MAX_REQUESTS  = MAX_REQUESTS_DEF,
    parameter int CYLINDER_BITS = CYLINDER_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // request channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [CYL_W-1:0]     s_cylinder,
    input  logic                 s_batch_end,
    // visit channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [CYL_W-1:0]     m_visit_cylinder,
    output logic [MOVE_W-1:0]    m_moved_so_far,
    output logic                 m_final_visit,
    // register write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CYL_W-1:0]     cfg_data
);

    // stored cylinder width: the mask of CYLINDER_BITS, never wider than the port
    localparam int CW = (CYLINDER_BITS < CYL_W) ? CYLINDER_BITS : CYL_W;
    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,  // collect requests
        ST_SKIP = 4'b0010,  // rotate past the low requests
        ST_PH1  = 4'b0100,  // first sweep
        ST_PH2  = 4'b1000   // return sweep
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;  // requests in the ring
    logic [CNT_W-1:0]   cnt_reg, cnt_next;      // skip steps, then visits released
    logic [CW-1:0]      head_reg, head_next;
    logic [CW-1:0]      pivot_reg, pivot_next;  // head at batch start
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               sweep_right_reg, sweep_right_next;

    logic               m_valid_reg, m_valid_next;
    logic [CYL_W-1:0]   m_visit_reg, m_visit_next;
    logic [MOVE_W-1:0]  m_moved_reg, m_moved_next;
    logic               m_final_reg, m_final_next;

    // ring of cells
    cell_op_t            op;
    logic                kill;
    logic [CW-1:0]       key;
    logic [CW-1:0]       cell_val [MAX_REQUESTS];
    logic [MAX_REQUESTS-1:0] cell_vld;
    logic [MAX_REQUESTS-1:0] cell_gt;

    assign key = s_cylinder[CW-1:0];

    for (genvar i = 0; i < MAX_REQUESTS; i++) begin : g_cell
        localparam int DN = (i == 0) ? MAX_REQUESTS - 1 : i - 1;
        localparam int UP = (i == MAX_REQUESTS - 1) ? 0 : i + 1;

        logic dn_vld_in, up_vld_in, dn_gt_in, dn_fill_in;

        // the cell that wraps around the ring on a release is dropped
        if (i == 0) begin : g_first
            assign dn_vld_in  = cell_vld[DN] && !kill;
            assign dn_gt_in   = 1'b0;
            assign dn_fill_in = 1'b1;
        end else begin : g_rest
            assign dn_vld_in  = cell_vld[DN];
            assign dn_gt_in   = cell_gt[DN];
            assign dn_fill_in = cell_vld[DN];
        end
        if (i == MAX_REQUESTS - 1) begin : g_last
            assign up_vld_in = cell_vld[UP] && !kill;
        end else begin : g_mid
            assign up_vld_in = cell_vld[UP];
        end

        lds_cell #(
            .W(CW)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .op      (op),
            .key     (key),
            .dn_val  (cell_val[DN]),
            .dn_vld  (dn_vld_in),
            .dn_gt   (dn_gt_in),
            .dn_fill (dn_fill_in),
            .up_val  (cell_val[UP]),
            .up_vld  (up_vld_in),
            .val     (cell_val[i]),
            .vld     (cell_vld[i]),
            .gt      (cell_gt[i])
        );
    end

    // Ports
    assign s_ready          = (state_reg == ST_IDLE);
    assign cfg_ready        = 1'b1;
    assign m_valid          = m_valid_reg;
    assign m_visit_cylinder = m_visit_reg;
    assign m_moved_so_far   = m_moved_reg;
    assign m_final_visit    = m_final_reg;

    // Class test against the pivot. "Low" requests are served on the return sweep when
    // sweeping right (below the pivot) and on the first sweep when sweeping left (at or
    // below the pivot).
    logic c0_low, cl_low;
    assign c0_low = sweep_right_reg ? (cell_val[0] < pivot_reg) : (cell_val[0] <= pivot_reg);
    assign cl_low = sweep_right_reg ? (cell_val[MAX_REQUESTS-1] < pivot_reg)
                                    : (cell_val[MAX_REQUESTS-1] <= pivot_reg);

    // Release tap: cell 0 when walking up the sorted order, the top cell when walking down
    logic          walk_dn;
    logic [CW-1:0] tap_val;
    logic          tap_vld, tap_low;
    assign walk_dn = sweep_right_reg ^ (state_reg == ST_PH2);
    assign tap_val = walk_dn ? cell_val[0] : cell_val[MAX_REQUESTS-1];
    assign tap_vld = walk_dn ? cell_vld[0] : cell_vld[MAX_REQUESTS-1];
    assign tap_low = walk_dn ? c0_low : cl_low;

    // Head movement for the tapped request
    logic [CW-1:0]      step_len;
    logic [SUM_W-1:0]   sum;
    logic [TOTAL_W-1:0] total_sat;
    logic [MOVE_W-1:0]  moved_sat;
    always_comb begin
        step_len  = (tap_val > head_reg) ? tap_val - head_reg : head_reg - tap_val;
        sum       = SUM_W'(total_reg) + SUM_W'(step_len);
        total_sat = (sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
        moved_sat = (total_sat > TOTAL_W'(MOVE_MAX)) ? MOVE_MAX : total_sat[MOVE_W-1:0];
    end

    logic out_free, emit, last, p1_match;
    logic [CNT_W-1:0] cnt_inc;
    assign out_free = !m_valid_reg || m_ready;
    assign cnt_inc  = cnt_reg + 1'b1;
    assign last     = (cnt_inc == count_reg);
    assign p1_match = tap_vld && (sweep_right_reg ? !tap_low : tap_low);

    // Sequencer
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        cnt_next   = cnt_reg;
        pivot_next = pivot_reg;
        op         = OP_HOLD;
        kill       = 1'b0;
        emit       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    // drop the request when the ring is full
                    if (!cell_vld[MAX_REQUESTS-1]) begin
                        op         = OP_INSERT;
                        count_next = count_reg + 1'b1;
                    end
                    if (s_batch_end) begin
                        state_next = ST_SKIP;
                        pivot_next = head_reg;
                        cnt_next   = '0;
                    end
                end
            end
            ST_SKIP: begin
                // rotate the low requests behind the ring origin
                if (cell_vld[0] && c0_low && (cnt_reg != count_reg)) begin
                    op       = OP_ROT_DN;
                    cnt_next = cnt_inc;
                end else begin
                    state_next = ST_PH1;
                    cnt_next   = '0;
                end
            end
            ST_PH1: begin
                if (p1_match) begin
                    emit = out_free;
                end else begin
                    state_next = ST_PH2;
                end
            end
            ST_PH2: begin
                if (tap_vld) begin
                    emit = out_free;
                end else begin
                    op = walk_dn ? OP_ROT_DN : OP_ROT_UP;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit) begin
            op       = walk_dn ? OP_ROT_DN : OP_ROT_UP;
            kill     = 1'b1;
            cnt_next = cnt_inc;
            if (last) begin
                state_next = ST_IDLE;
                count_next = '0;
                cnt_next   = '0;
            end
        end
    end

    // Head, movement total, registers and the output stage
    always_comb begin
        head_next        = head_reg;
        total_next       = total_reg;
        sweep_right_next = sweep_right_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_visit_next     = m_visit_reg;
        m_moved_next     = m_moved_reg;
        m_final_next     = m_final_reg;

        if (state_reg == ST_IDLE && s_valid && s_batch_end) begin
            total_next = '0;
        end

        if (emit) begin
            head_next    = tap_val;
            total_next   = total_sat;
            m_valid_next = 1'b1;
            m_visit_next = CYL_W'(tap_val);
            m_moved_next = moved_sat;
            m_final_next = last;
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_START_HEAD:  head_next = cfg_data[CW-1:0];
                REG_SWEEP_RIGHT: sweep_right_next = cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            cnt_reg         <= '0;
            head_reg        <= '0;
            total_reg       <= '0;
            sweep_right_reg <= 1'b1;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            cnt_reg         <= cnt_next;
            head_reg        <= head_next;
            total_reg       <= total_next;
            sweep_right_reg <= sweep_right_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pivot_reg   <= pivot_next;
        m_visit_reg <= m_visit_next;
        m_moved_reg <= m_moved_next;
        m_final_reg <= m_final_next;
    end

`ifndef SYNTHESIS
    // While collecting, the ring holds exactly the counted requests
    a_count_matches_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> ($countones(cell_vld) == int'(count_reg)))
        else $error("ring occupancy differs from request count");

    // The last visit empties the ring and returns to collecting
    a_last_visit_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && last) |=> ((state_reg == ST_IDLE) && (cell_vld == '0)))
        else $error("ring not empty after final visit");

    // Released visits never outrun the stored requests
    a_release_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_PH1) || (state_reg == ST_PH2)) |-> (cnt_reg < count_reg))
        else $error("visit count beyond request count");
`endif

endmodule

// ===== src/lds_cell.sv =====
// One cell of the sorted request ring: a cylinder value and its valid flag.
// Depends on lds_pkg for the cell command type.
module lds_cell import lds_pkg::*; #(
    parameter int W = CYLINDER_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  cell_op_t     op,
    input  logic [W-1:0] key,
    input  logic [W-1:0] dn_val,
    input  logic         dn_vld,
    input  logic         dn_gt,
    input  logic         dn_fill,
    input  logic [W-1:0] up_val,
    input  logic         up_vld,
    output logic [W-1:0] val,
    output logic         vld,
    output logic         gt
);

    logic [W-1:0] val_reg, val_next;
    logic         vld_reg, vld_next;

    assign val = val_reg;
    assign vld = vld_reg;
    assign gt  = vld_reg && (val_reg > key);

    always_comb begin
        val_next = val_reg;
        vld_next = vld_reg;
        unique case (op)
            OP_HOLD: begin
            end
            OP_INSERT: begin
                // take the shifted neighbor or the new key at the insert point
                if (gt || (!vld_reg && dn_fill)) begin
                    val_next = dn_gt ? dn_val : key;
                    vld_next = 1'b1;
                end
            end
            OP_ROT_DN: begin
                val_next = up_val;
                vld_next = up_vld;
            end
            OP_ROT_UP: begin
                val_next = dn_val;
                vld_next = dn_vld;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

endmodule
